>>> hdl/assert_macros.svh
// Concurrent assertion helpers; expect clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cbq_pkg.sv
package cbq_pkg;

  localparam int DEF_MAX_STAGES  = 8;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int HIST_BITS  = 40;
  localparam int COEF_BITS  = 32;
  localparam int GAIN_BITS  = 32;
  localparam int SPLIT_BITS = 20;
  localparam int ACC_BITS   = 76;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 32'h0100_0000;
  localparam logic [3:0]           STAGES_RESET = 4'd1;

  typedef enum logic [2:0] {
    REG_FILTER_ENABLE,
    REG_INPUT_GAIN,
    REG_STAGES_USED,
    REG_COEF_FEED_ZERO,
    REG_COEF_FEED_ONE,
    REG_COEF_FEED_TWO,
    REG_COEF_BACK_ONE,
    REG_COEF_BACK_TWO
  } cbq_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_GAIN_ACC,
    ST_GAIN_FIN,
    ST_SEC_MUL,
    ST_SEC_ACC,
    ST_SEC_FIN,
    ST_OUT
  } cbq_state_t;

  typedef enum logic [2:0] {
    TAP_X0,
    TAP_X1,
    TAP_X2,
    TAP_Y1,
    TAP_Y2
  } cbq_tap_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    logic     mul_gain;
    cbq_tap_t tap;
    logic     fin_gain;
    logic     fin_sec;
    logic     out_load;
  } cbq_cmd_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] feed_zero;
    logic signed [COEF_BITS-1:0] feed_one;
    logic signed [COEF_BITS-1:0] feed_two;
    logic signed [COEF_BITS-1:0] back_one;
    logic signed [COEF_BITS-1:0] back_two;
  } cbq_coef_t;

  // Clamp an accumulator-wide value to the signed history width.
  function automatic logic signed [HIST_BITS-1:0] sat_hist(
    input logic signed [ACC_BITS-1:0] v
  );
    logic sign;
    logic any_one;
    logic all_one;
    sign    = v[ACC_BITS-1];
    any_one = |v[ACC_BITS-2:HIST_BITS-1];
    all_one = &v[ACC_BITS-2:HIST_BITS-1];
    if (!sign && any_one) begin
      return {1'b0, {(HIST_BITS-1){1'b1}}};
    end else if (sign && !all_one) begin
      return {1'b1, {(HIST_BITS-1){1'b0}}};
    end
    return v[HIST_BITS-1:0];
  endfunction

endpackage

>>> hdl/cbq_ctrl.sv
`include "assert_macros.svh"

module cbq_ctrl import cbq_pkg::*; #(
  parameter int MAX_STAGES = DEF_MAX_STAGES,
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          filter_enable,
  input  logic [3:0]    stages_used,
  output cbq_cmd_t      cmd,
  output logic [SW-1:0] stage
);

  cbq_state_t    state, state_next;
  cbq_tap_t      tap, tap_next;
  logic [SW-1:0] stage_next;
  logic          out_valid_next;
  logic [SW-1:0] last_stage;
  logic [5:0]    su_wide;

  // Zero sections act as one, too many act as the maximum.
  assign su_wide = {2'b00, stages_used};
  always_comb begin
    if (stages_used == 4'd0) begin
      last_stage = '0;
    end else if (su_wide >= 6'(MAX_STAGES)) begin
      last_stage = SW'(MAX_STAGES - 1);
    end else begin
      last_stage = SW'(stages_used - 4'd1);
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= TAP_X0;
      stage     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tap       <= tap_next;
      stage     <= stage_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    stage_next = stage;
    cmd        = '0;
    cmd.tap    = tap;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          stage_next = '0;
          tap_next   = TAP_X0;
          state_next = filter_enable ? ST_GAIN_MUL : ST_OUT;
        end
      end
      ST_GAIN_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
        state_next   = ST_GAIN_ACC;
      end
      ST_GAIN_ACC: begin
        state_next = ST_GAIN_FIN;
      end
      ST_GAIN_FIN: begin
        cmd.fin_gain = 1'b1;
        state_next   = ST_SEC_MUL;
      end
      ST_SEC_MUL: begin
        // one tap per cycle; the previous product accumulates alongside
        cmd.mul_en = 1'b1;
        if (tap == TAP_Y2) begin
          state_next = ST_SEC_ACC;
        end else begin
          tap_next = cbq_tap_t'(tap + 3'd1);
        end
      end
      ST_SEC_ACC: begin
        state_next = ST_SEC_FIN;
      end
      ST_SEC_FIN: begin
        cmd.fin_sec = 1'b1;
        tap_next    = TAP_X0;
        if (stage == last_stage) begin
          state_next = ST_OUT;
        end else begin
          stage_next = stage + 1'b1;
          state_next = ST_SEC_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  `CBQ_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != ST_IDLE,
    "accepted transfer did not start processing")
  `CBQ_ASSERT_NEXT(a_last_section_outputs, (state == ST_SEC_FIN) && (stage == last_stage),
    state == ST_OUT, "last section did not lead to output")
  `CBQ_ASSERT_SAME(a_out_load_free, cmd.out_load, !out_valid || !out_stall,
    "output register overwritten while held")

endmodule

>>> hdl/cbq_datapath.sv
`include "assert_macros.svh"

module cbq_datapath import cbq_pkg::*; #(
  parameter int MAX_STAGES  = DEF_MAX_STAGES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbq_cmd_t                      cmd,
  input  logic [SW-1:0]                 stage,
  input  logic                          hist_clear,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [GAIN_BITS-1:0]          input_gain,
  input  cbq_coef_t                     coef,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int PH_BITS = COEF_BITS + 1 + SPLIT_BITS;
  localparam int PL_BITS = COEF_BITS + 1 + SPLIT_BITS + 1;
  localparam int VH_BITS = HIST_BITS - SPLIT_BITS;

  localparam logic signed [ACC_BITS-1:0] GAIN_RND = ACC_BITS'(64'd1 << 23);
  localparam logic signed [ACC_BITS-1:0] SEC_RND  = ACC_BITS'(64'd1 << 27);

  logic signed [HIST_BITS-1:0] hist_x1 [MAX_STAGES];
  logic signed [HIST_BITS-1:0] hist_x2 [MAX_STAGES];
  logic signed [HIST_BITS-1:0] hist_y1 [MAX_STAGES];
  logic signed [HIST_BITS-1:0] hist_y2 [MAX_STAGES];

  logic signed [HIST_BITS-1:0] cur;
  logic signed [HIST_BITS-1:0] operand;
  logic signed [COEF_BITS-1:0] coef_sel;
  logic signed [COEF_BITS:0]   mult_a;
  logic signed [VH_BITS-1:0]   v_hi;
  logic signed [SPLIT_BITS:0]  v_lo;
  logic signed [PH_BITS-1:0]   prod_hi;
  logic signed [PL_BITS-1:0]   prod_lo;
  logic                        prod_valid;
  logic signed [ACC_BITS-1:0]  acc, acc_next;
  logic signed [ACC_BITS-1:0]  rounded, shifted;
  logic signed [HIST_BITS-1:0] fin_value;
  logic                        out_hi, out_lo;

  // Operand and coefficient for this tap
  always_comb begin
    case (cmd.tap)
      TAP_X0: begin
        operand  = cur;
        coef_sel = coef.feed_zero;
      end
      TAP_X1: begin
        operand  = hist_x1[stage];
        coef_sel = coef.feed_one;
      end
      TAP_X2: begin
        operand  = hist_x2[stage];
        coef_sel = coef.feed_two;
      end
      TAP_Y1: begin
        operand  = hist_y1[stage];
        coef_sel = coef.back_one;
      end
      TAP_Y2: begin
        operand  = hist_y2[stage];
        coef_sel = coef.back_two;
      end
      default: begin
        operand  = cur;
        coef_sel = coef.feed_zero;
      end
    endcase
    if (cmd.mul_gain) begin
      operand = cur;
      mult_a  = $signed({1'b0, input_gain});
    end else begin
      mult_a  = $signed({coef_sel[COEF_BITS-1], coef_sel});
    end
  end

  // 40-bit operand split as floor part and non-negative 20-bit remainder
  assign v_hi = operand[HIST_BITS-1:SPLIT_BITS];
  assign v_lo = $signed({1'b0, operand[SPLIT_BITS-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_hi <= mult_a * v_hi;
      prod_lo <= mult_a * v_lo;
    end
  end

  assign acc_next = acc
                  + $signed({{(ACC_BITS-PH_BITS-SPLIT_BITS){prod_hi[PH_BITS-1]}}, prod_hi,
                             {SPLIT_BITS{1'b0}}})
                  + $signed({{(ACC_BITS-PL_BITS){prod_lo[PL_BITS-1]}}, prod_lo});

  // Round half up, then scale back to sample units
  assign rounded   = acc + (cmd.fin_gain ? GAIN_RND : SEC_RND);
  assign shifted   = cmd.fin_gain ? (rounded >>> 24) : (rounded >>> 28);
  assign fin_value = sat_hist(shifted);

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.fin_gain || cmd.fin_sec) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= {{(HIST_BITS-SAMPLE_BITS){sample_in[SAMPLE_BITS-1]}}, sample_in};
    end else if (cmd.fin_gain || cmd.fin_sec) begin
      cur <= fin_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || hist_clear) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        hist_x1[i] <= '0;
        hist_x2[i] <= '0;
        hist_y1[i] <= '0;
        hist_y2[i] <= '0;
      end
    end else if (cmd.fin_sec) begin
      hist_x1[stage] <= cur;
      hist_x2[stage] <= hist_x1[stage];
      hist_y1[stage] <= fin_value;
      hist_y2[stage] <= hist_y1[stage];
    end
  end

  // Saturate to the sample width
  assign out_hi = !cur[HIST_BITS-1] && (|cur[HIST_BITS-2:SAMPLE_BITS-1]);
  assign out_lo = cur[HIST_BITS-1] && !(&cur[HIST_BITS-2:SAMPLE_BITS-1]);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (out_hi) begin
        sample_out <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (out_lo) begin
        sample_out <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        sample_out <= cur[SAMPLE_BITS-1:0];
      end
    end
  end

  `CBQ_ASSERT_NEXT(a_load_clears_acc, cmd.load, acc == '0,
    "accumulator not cleared on new sample")

endmodule

>>> hdl/cascaded_biquad_bandpass_core.sv
// Cascaded direct-form-I biquad band-pass filter. Each sample is scaled by
// input_gain (unsigned Q8.24) and run through stages_used identical sections
// with signed Q3.28 coefficients; the result is saturated to the sample width.
// With filter_enable low the sample is passed through and history is left
// alone. A filtered sample runs through a gain step and then the N sections in
// use, and the next sample is taken only once the result is loaded for output:
// a 33x21 and a 33x20 multiplier work one coefficient tap per cycle, five
// taps per section, then each section drains and rounds. Bypass skips these.
// The output register holds a result while the next sample is taken in.
// Any register write clears all section history; write only while idle.
`include "assert_macros.svh"

module cascaded_biquad_bandpass_core import cbq_pkg::*; #(
  parameter int MAX_STAGES  = DEF_MAX_STAGES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready
);

  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  logic                 filter_enable;
  logic [GAIN_BITS-1:0] input_gain;
  logic [3:0]           stages_used;
  cbq_coef_t            coef;
  logic                 cfg_wr;
  cbq_reg_t             reg_idx;
  cbq_cmd_t             cmd;
  logic [SW-1:0]        stage;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = cbq_reg_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      input_gain    <= GAIN_RESET;
      stages_used   <= STAGES_RESET;
      coef          <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FILTER_ENABLE:  filter_enable  <= pwdata[0];
        REG_INPUT_GAIN:     input_gain     <= pwdata;
        REG_STAGES_USED:    stages_used    <= pwdata[3:0];
        REG_COEF_FEED_ZERO: coef.feed_zero <= pwdata;
        REG_COEF_FEED_ONE:  coef.feed_one  <= pwdata;
        REG_COEF_FEED_TWO:  coef.feed_two  <= pwdata;
        REG_COEF_BACK_ONE:  coef.back_one  <= pwdata;
        REG_COEF_BACK_TWO:  coef.back_two  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILTER_ENABLE:  prdata = {{(DATA_BITS-1){1'b0}}, filter_enable};
      REG_INPUT_GAIN:     prdata = input_gain;
      REG_STAGES_USED:    prdata = {{(DATA_BITS-4){1'b0}}, stages_used};
      REG_COEF_FEED_ZERO: prdata = coef.feed_zero;
      REG_COEF_FEED_ONE:  prdata = coef.feed_one;
      REG_COEF_FEED_TWO:  prdata = coef.feed_two;
      REG_COEF_BACK_ONE:  prdata = coef.back_one;
      REG_COEF_BACK_TWO:  prdata = coef.back_two;
      default:            prdata = '0;
    endcase
  end

  cbq_ctrl #(
    .MAX_STAGES (MAX_STAGES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .filter_enable (filter_enable),
    .stages_used   (stages_used),
    .cmd           (cmd),
    .stage         (stage)
  );

  // every listed register write clears the section history
  cbq_datapath #(
    .MAX_STAGES  (MAX_STAGES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stage      (stage),
    .hist_clear (cfg_wr),
    .sample_in  (sample_in),
    .input_gain (input_gain),
    .coef       (coef),
    .sample_out (sample_out)
  );

endmodule

>>> bench/testbench.sv
module testbench;
  import cbq_pkg::*;

  localparam int MAX_STAGES = DEF_MAX_STAGES;
  localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
  localparam int SAMPLES_PER_PHASE = 75;
  localparam int RANDOM_PHASES = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [HIST_BITS-1:0] hist_t;
  typedef logic signed [79:0] wide_t;

  // Fixed-point predictor plus the queue of samples the filter still owes us.
  class biquad_tracker;
    localparam wide_t HIST_TOP = (80'sd1 <<< (HIST_BITS - 1)) - 80'sd1;
    localparam wide_t HIST_BOTTOM = -(80'sd1 <<< (HIST_BITS - 1));
    localparam wide_t SECTION_HALF = 80'sd1 <<< 27;
    localparam hist_t SAMPLE_TOP = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
    localparam hist_t SAMPLE_BOTTOM = -(40'sd1 <<< (SAMPLE_BITS - 1));

    logic enable;
    logic [GAIN_BITS-1:0] gain;
    logic [3:0] stages;
    logic signed [COEF_BITS-1:0] feed_zero, feed_one, feed_two, back_one, back_two;
    hist_t x_one[MAX_STAGES], x_two[MAX_STAGES], y_one[MAX_STAGES], y_two[MAX_STAGES];
    sample_t owed_samples[$];
    int failures;
    int compared;

    function new();
      enable = 1'b0;
      gain = GAIN_RESET;
      stages = STAGES_RESET;
      feed_zero = '0;
      feed_one = '0;
      feed_two = '0;
      back_one = '0;
      back_two = '0;
      failures = 0;
      compared = 0;
      clear_history();
    endfunction

    function void clear_history();
      for (int n = 0; n < MAX_STAGES; n++) begin
        x_one[n] = '0;
        x_two[n] = '0;
        y_one[n] = '0;
        y_two[n] = '0;
      end
    endfunction

    // every register write wipes the section history
    function void write_reg(cbq_reg_t idx, logic [DATA_BITS-1:0] val);
      case (idx)
        REG_FILTER_ENABLE: enable = val[0];
        REG_INPUT_GAIN: gain = val;
        REG_STAGES_USED: stages = val[3:0];
        REG_COEF_FEED_ZERO: feed_zero = val;
        REG_COEF_FEED_ONE: feed_one = val;
        REG_COEF_FEED_TWO: feed_two = val;
        REG_COEF_BACK_ONE: back_one = val;
        REG_COEF_BACK_TWO: back_two = val;
        default: ;
      endcase
      clear_history();
    endfunction

    function wide_t tap(logic signed [COEF_BITS-1:0] c, hist_t v);
      wide_t cw, vw;
      cw = c;
      vw = v;
      return cw * vw;
    endfunction

    function sample_t filter_sample(sample_t s);
      longint scaled;
      hist_t x0, y;
      wide_t acc;
      int count;
      if (!enable) return s;
      count = (stages == 0) ? 1 : ((stages > MAX_STAGES) ? MAX_STAGES : stages);
      // gain product stays far inside 40 bits, so no clamp is needed here
      scaled = (longint'(s) * longint'(gain) + (longint'(1) <<< 23)) >>> 24;
      x0 = scaled[HIST_BITS-1:0];
      for (int n = 0; n < count; n++) begin
        acc = tap(feed_zero, x0) + tap(feed_one, x_one[n]) + tap(feed_two, x_two[n])
            + tap(back_one, y_one[n]) + tap(back_two, y_two[n]);
        acc = (acc + SECTION_HALF) >>> 28;
        if (acc > HIST_TOP) y = HIST_TOP[HIST_BITS-1:0];
        else if (acc < HIST_BOTTOM) y = HIST_BOTTOM[HIST_BITS-1:0];
        else y = acc[HIST_BITS-1:0];
        y_two[n] = y_one[n];
        y_one[n] = y;
        x_two[n] = x_one[n];
        x_one[n] = x0;
        x0 = y;
      end
      if (x0 > SAMPLE_TOP) return SAMPLE_TOP[SAMPLE_BITS-1:0];
      if (x0 < SAMPLE_BOTTOM) return SAMPLE_BOTTOM[SAMPLE_BITS-1:0];
      return x0[SAMPLE_BITS-1:0];
    endfunction

    function void note_input(sample_t s);
      owed_samples.push_back(filter_sample(s));
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (owed_samples.size() == 0) begin
        $error("sample_out: no transfer pending, got %0d", got);
        failures++;
        return;
      end
      want = owed_samples.pop_front();
      compared++;
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction

    function int pending();
      return owed_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  biquad_tracker tracker = new();
  bit hold_off_request = 1'b0;
  bit held_off = 1'b0;
  int samples_sent = 0;
  int settings_used = 0;

  cascaded_biquad_bandpass_core #(
    .MAX_STAGES(MAX_STAGES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(sample_out);
  end

  // output side: random ready runs and short stalls, long free stretches now and then,
  // and one long hold-off on request
  initial begin
    int run;
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
        held_off = 1'b1;
      end else begin
        run = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        if ($urandom_range(0, 3) != 0) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input cbq_reg_t idx, input logic [DATA_BITS-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // writes all eight registers in shuffled order; junk fills unused upper bits
  task automatic program_filter(input logic en, input logic [31:0] gain,
                                input logic [3:0] stages, input logic [31:0] a0,
                                input logic [31:0] a1, input logic [31:0] a2,
                                input logic [31:0] b1, input logic [31:0] b2,
                                input bit junk);
    logic [DATA_BITS-1:0] vals[8];
    logic [DATA_BITS-1:0] upper;
    int order[$];
    upper = junk ? $urandom : '0;
    vals[REG_FILTER_ENABLE] = {upper[31:1], en};
    vals[REG_INPUT_GAIN] = gain;
    vals[REG_STAGES_USED] = {upper[31:4], stages};
    vals[REG_COEF_FEED_ZERO] = a0;
    vals[REG_COEF_FEED_ONE] = a1;
    vals[REG_COEF_FEED_TWO] = a2;
    vals[REG_COEF_BACK_ONE] = b1;
    vals[REG_COEF_BACK_TWO] = b2;
    for (int i = 0; i < 8; i++) order.push_back(i);
    order.shuffle();
    foreach (order[k]) write_reg(cbq_reg_t'(order[k]), vals[order[k]]);
    settings_used++;
  endtask

  task automatic send_sample(input sample_t s);
    in_valid <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(s);
    samples_sent++;
  endtask

  task automatic await_drain();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // block is idle once nothing is owed and a settling wait has passed
  task automatic settle();
    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_list(input sample_t list[$]);
    foreach (list[i]) send_sample(list[i]);
    in_valid <= 1'b0;
    settle();
  endtask

  task automatic stream_samples(input int count, input bit steady);
    int burst_left;
    sample_t s;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(0, 3) == 0) ? sample_t'($signed($urandom_range(0, 512)) - 256)
                                       : sample_t'($urandom);
      send_sample(s);
      burst_left--;
      if (!steady && burst_left <= 0) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 39) == 0) await_drain();
        repeat ($urandom_range(1, 15)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
      end
    end
    in_valid <= 1'b0;
  endtask

  localparam logic [31:0] UNITY_COEF = 32'h1000_0000;
  localparam logic [31:0] UNITY_GAIN = 32'h0100_0000;

  initial begin
    logic en;
    logic [31:0] gain, a0, a1, a2, b1, b2;
    logic [3:0] stages;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset state is bypass
    send_list('{-24'sd8388608, 24'sd8388607, 24'sd0, -24'sd1, 24'sh555555, 24'shAAAAAA});

    // identity section, stage count zero acts as one
    program_filter(1'b1, UNITY_GAIN, 4'd0, UNITY_COEF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_list('{24'sd8388607, -24'sd8388608, 24'sd1, -24'sd1});

    // half gain hits exact rounding ties
    program_filter(1'b1, 32'h0080_0000, 4'd1, UNITY_COEF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_list('{24'sd1, -24'sd1, 24'sd3, -24'sd3});

    // full gain, extreme coefficients, stage count above max: history saturates
    program_filter(1'b1, 32'hFFFF_FFFF, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_list('{24'sd8388607, -24'sd8388608, 24'sd8388607});

    // resonant band-pass over eight sections, impulse response
    program_filter(1'b1, UNITY_GAIN, 4'd8, 32'd13421773, 32'd0, -32'sd13421773,
                   32'd483183821, -32'sd241591910, 1'b0);
    send_list('{24'sd8388607, 24'sd0, 24'sd0, 24'sd0, -24'sd5});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      en = (p == 2) || ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 3))
        0: gain = UNITY_GAIN;
        1: gain = $urandom;
        2: gain = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        default: gain = $urandom_range(32'h0040_0000, 32'h0400_0000);
      endcase
      case (p)
        0: stages = 4'd8;
        1: stages = 4'd1;
        3: stages = 4'd15;
        4: stages = 4'd0;
        default: stages = $urandom_range(0, 15);
      endcase
      if (p % 3 != 2) begin
        // roughly stable resonator with random tuning
        a0 = $urandom_range(0, 32'h0400_0000);
        a1 = $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        a2 = -a0;
        b1 = $urandom_range(0, 32'h1E00_0000);
        if ($urandom_range(0, 1)) b1 = -b1;
        b2 = -$urandom_range(32'h0800_0000, 32'h0F00_0000);
      end else begin
        a0 = $urandom;
        a1 = $urandom;
        a2 = $urandom;
        b1 = $urandom;
        b2 = $urandom;
      end
      program_filter(en, gain, stages, a0, a1, a2, b1, b2, p % 2 == 1);
      if (p == 2) hold_off_request = 1'b1;
      stream_samples(SAMPLES_PER_PHASE, p == 2);
      settle();
    end

    $display("%0d samples over %0d filter settings, %0d results compared, %0d failures",
             samples_sent, settings_used, tracker.compared, tracker.failures);
    $display("long output hold-off of %0d cycles seen: %0d", HOLD_OFF_CYCLES, held_off);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
